FILE: rtl/cursor_linked_list_engine_core_macros.svh
// ----------------------------------------------------------------------------
// cursor_linked_list_engine_core_macros
// assertion helpers used by the linked list engine checker
// ----------------------------------------------------------------------------
`ifndef CURSOR_LINKED_LIST_ENGINE_CORE_MACROS_SVH
`define CURSOR_LINKED_LIST_ENGINE_CORE_MACROS_SVH

// same cycle implication under reset
`define CLL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("cll assertion failed");

// next cycle implication under reset
`define CLL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("cll assertion failed");

`endif

FILE: rtl/cll_pkg.sv
// ----------------------------------------------------------------------------
// cll_pkg
// sizes, codes and types of the cursor linked list engine
// ----------------------------------------------------------------------------
package cll_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);

  localparam int OP_W    = 2;
  localparam int POS_W   = 6;
  localparam int VALUE_W = 32;
  localparam int ST_W    = 2;
  localparam int ELEM_W  = 32;
  localparam int COUNT_W = 6;

  localparam int CMP_W = ((IDX_W > POS_W) ? IDX_W : POS_W) + 1;
  localparam int EXT_W = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [DATA_WIDTH-1:0] data_t;

  localparam idx_t HEAD_FREE  = '0;
  localparam idx_t HEAD_LIST  = idx_t'(DEPTH - 1);
  localparam idx_t LAST_ENTRY = idx_t'(DEPTH - 2);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef struct packed {
    logic  link_we;
    idx_t  link_waddr;
    idx_t  link_wdata;
    idx_t  link_raddr;
    logic  data_we;
    idx_t  data_waddr;
    data_t data_wdata;
    idx_t  data_raddr;
  } mem_req_t;

endpackage

FILE: rtl/cll_in_if.sv
// ----------------------------------------------------------------------------
// cll_in_if
// request channel of the linked list engine
// ----------------------------------------------------------------------------
interface cll_in_if;
  import cll_pkg::*;

  logic                      valid;
  logic                      ready;
  logic        [OP_W-1:0]    op;
  logic        [POS_W-1:0]   position;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, op, position, value, input ready);
  modport sink (input valid, op, position, value, output ready);

endinterface

FILE: rtl/cll_out_if.sv
// ----------------------------------------------------------------------------
// cll_out_if
// result channel of the linked list engine
// ----------------------------------------------------------------------------
interface cll_out_if;
  import cll_pkg::*;

  logic                     valid;
  logic                     ready;
  logic        [ST_W-1:0]   status;
  logic signed [ELEM_W-1:0] element;
  logic        [COUNT_W-1:0] count;
  logic                     last;

  modport source (output valid, status, element, count, last, input ready);
  modport sink (input valid, status, element, count, last, output ready);

endinterface

FILE: rtl/cll_store.sv
// ----------------------------------------------------------------------------
// cll_store
// link and data memories, one write and one registered read port each
// ----------------------------------------------------------------------------
module cll_store (
  input  logic              clk_i,
  input  cll_pkg::mem_req_t req_i,
  output cll_pkg::idx_t     link_rdata_o,
  output cll_pkg::data_t    data_rdata_o
);
  import cll_pkg::*;

  idx_t  link_mem [DEPTH];
  data_t data_mem [DEPTH];
  idx_t  link_rdata_q;
  data_t data_rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.link_we) begin
      link_mem[req_i.link_waddr] <= req_i.link_wdata;
    end
    link_rdata_q <= link_mem[req_i.link_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (req_i.data_we) begin
      data_mem[req_i.data_waddr] <= req_i.data_wdata;
    end
    data_rdata_q <= data_mem[req_i.data_raddr];
  end

  assign link_rdata_o = link_rdata_q;
  assign data_rdata_o = data_rdata_q;

endmodule

FILE: rtl/cursor_linked_list_engine_core.sv
// ----------------------------------------------------------------------------
// cursor_linked_list_engine_core
// singly linked list of values kept in a fixed array with index links
// ----------------------------------------------------------------------------
// in_i carries one request: insert value at a one-based position, delete
// the element at a position, or read out the whole list. out_o returns the
// results: one per insert, delete or rejected request, and one per element
// on a readout, with last set on the final one and the element count.
// A readout delivers one element per cycle while out_o accepts them. Inserts
// and deletes walk the list one link per cycle, readouts one link per element,
// through the single read port of the link memory, so a request holds the
// block for its whole walk.
// After reset the free chain is written into entries 1 to DEPTH - 2 of the
// link memory, one entry a cycle; in_i.ready stays low meanwhile.
// A new request is taken once the previous one has finished, even while its
// last result still waits in the output register. When out_o stalls, the
// result is held and a readout pauses until the register frees up.
// ----------------------------------------------------------------------------
module cursor_linked_list_engine_core (
  input logic        clk_i,
  input logic        rst_ni,
  cll_in_if.sink     in_i,
  cll_out_if.source  out_o
);
  import cll_pkg::*;

  typedef enum logic [9:0] {
    S_INIT    = 10'b0000000001,
    S_IDLE    = 10'b0000000010,
    S_FREE    = 10'b0000000100,
    S_WALK    = 10'b0000001000,
    S_LINK    = 10'b0000010000,
    S_DEL_A   = 10'b0000100000,
    S_DEL_B   = 10'b0001000000,
    S_RO_EMIT = 10'b0010000000,
    S_RESP    = 10'b0100000000,
    S_SPARE   = 10'b1000000000
  } state_e;

  state_e  state_q, state_d;
  idx_t    cur_q, cur_d;
  idx_t    steps_q, steps_d;
  idx_t    j_q, j_d;
  logic    [OP_W-1:0] op_q, op_d;
  data_t   val_q, val_d;
  idx_t    free_head_q, free_head_d;
  idx_t    list_head_q, list_head_d;
  idx_t    count_q, count_d;
  idx_t    init_idx_q, init_idx_d;
  status_e rsp_status_q, rsp_status_d;

  logic                oval_q, oval_d;
  logic [ST_W-1:0]     ost_q, ost_d;
  logic [ELEM_W-1:0]   oelem_q, oelem_d;
  logic [COUNT_W-1:0]  ocount_q, ocount_d;
  logic                olast_q, olast_d;

  mem_req_t mem_req;
  idx_t     link_rdata;
  data_t    data_rdata;
  idx_t     nxt;
  logic     rd_ovr;
  idx_t     rd_ovr_addr;

  logic                can_push;
  logic                push;
  logic [ST_W-1:0]     push_st;
  logic [ELEM_W-1:0]   push_elem;
  logic                push_last;

  logic [CMP_W-1:0] pos_x, cnt_x;
  logic             ins_ok, del_ok;
  logic [EXT_W-1:0] val_ext, elem_ext;

  cll_store u_store (
    .clk_i        (clk_i),
    .req_i        (mem_req),
    .link_rdata_o (link_rdata),
    .data_rdata_o (data_rdata)
  );

  assign nxt      = (cur_q == HEAD_LIST) ? list_head_q : link_rdata;
  assign can_push = !oval_q || out_o.ready;
  assign pos_x    = CMP_W'(in_i.position);
  assign cnt_x    = CMP_W'(count_q);
  assign ins_ok   = (pos_x != '0) && (pos_x <= cnt_x + CMP_W'(1));
  assign del_ok   = (pos_x != '0) && (pos_x <= cnt_x);
  assign val_ext  = EXT_W'($unsigned(in_i.value));
  assign elem_ext = EXT_W'(data_rdata);

  assign in_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    steps_d      = steps_q;
    j_d          = j_q;
    op_d         = op_q;
    val_d        = val_q;
    free_head_d  = free_head_q;
    list_head_d  = list_head_q;
    count_d      = count_q;
    init_idx_d   = init_idx_q;
    rsp_status_d = rsp_status_q;
    mem_req      = '0;
    rd_ovr       = 1'b0;
    rd_ovr_addr  = '0;
    push         = 1'b0;
    push_st      = ST_OK;
    push_elem    = '0;
    push_last    = 1'b1;

    unique case (state_q)
      S_INIT: begin
        mem_req.link_we    = 1'b1;
        mem_req.link_waddr = init_idx_q;
        mem_req.link_wdata = (init_idx_q == LAST_ENTRY) ? HEAD_FREE : init_idx_q + idx_t'(1);
        init_idx_d         = init_idx_q + idx_t'(1);
        if (init_idx_q == LAST_ENTRY) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_i.valid) begin
          op_d  = in_i.op;
          val_d = val_ext[DATA_WIDTH-1:0];
          unique case (in_i.op)
            OP_INSERT: begin
              if (!ins_ok) begin
                rsp_status_d = ST_BAD_POS;
                state_d      = S_RESP;
              end else if (free_head_q == HEAD_FREE) begin
                rsp_status_d = ST_FULL;
                state_d      = S_RESP;
              end else begin
                j_d         = free_head_q;
                steps_d     = idx_t'(pos_x - CMP_W'(1));
                rd_ovr      = 1'b1;
                rd_ovr_addr = free_head_q;
                state_d     = S_FREE;
              end
            end
            OP_DELETE: begin
              if (!del_ok) begin
                rsp_status_d = ST_BAD_POS;
                state_d      = S_RESP;
              end else begin
                cur_d   = HEAD_LIST;
                steps_d = idx_t'(pos_x - CMP_W'(1));
                state_d = S_WALK;
              end
            end
            OP_READ: begin
              if (count_q == '0) begin
                rsp_status_d = ST_EMPTY;
                state_d      = S_RESP;
              end else begin
                cur_d   = list_head_q;
                steps_d = count_q - idx_t'(1);
                state_d = S_RO_EMIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_FREE: begin
        free_head_d = link_rdata;
        cur_d       = HEAD_LIST;
        state_d     = S_WALK;
      end
      S_WALK: begin
        if (steps_q != '0) begin
          cur_d   = nxt;
          steps_d = steps_q - idx_t'(1);
        end else if (op_q == OP_INSERT) begin
          mem_req.link_we    = 1'b1;
          mem_req.link_waddr = j_q;
          mem_req.link_wdata = nxt;
          state_d            = S_LINK;
        end else begin
          j_d         = nxt;
          rd_ovr      = 1'b1;
          rd_ovr_addr = nxt;
          state_d     = S_DEL_A;
        end
      end
      S_LINK: begin
        if (cur_q == HEAD_LIST) begin
          list_head_d = j_q;
        end else begin
          mem_req.link_we    = 1'b1;
          mem_req.link_waddr = cur_q;
          mem_req.link_wdata = j_q;
        end
        mem_req.data_we    = 1'b1;
        mem_req.data_waddr = j_q;
        mem_req.data_wdata = val_q;
        count_d            = count_q + idx_t'(1);
        rsp_status_d       = ST_OK;
        state_d            = S_RESP;
      end
      S_DEL_A: begin
        if (cur_q == HEAD_LIST) begin
          list_head_d = link_rdata;
        end else begin
          mem_req.link_we    = 1'b1;
          mem_req.link_waddr = cur_q;
          mem_req.link_wdata = link_rdata;
        end
        state_d = S_DEL_B;
      end
      S_DEL_B: begin
        mem_req.link_we    = 1'b1;
        mem_req.link_waddr = j_q;
        mem_req.link_wdata = free_head_q;
        free_head_d        = j_q;
        count_d            = count_q - idx_t'(1);
        rsp_status_d       = ST_OK;
        state_d            = S_RESP;
      end
      S_RO_EMIT: begin
        if (can_push) begin
          push      = 1'b1;
          push_st   = ST_OK;
          push_elem = elem_ext[ELEM_W-1:0];
          push_last = (steps_q == '0);
          if (steps_q == '0) begin
            state_d = S_IDLE;
          end else begin
            cur_d   = nxt;
            steps_d = steps_q - idx_t'(1);
          end
        end
      end
      S_RESP: begin
        if (can_push) begin
          push    = 1'b1;
          push_st = rsp_status_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    mem_req.link_raddr = rd_ovr ? rd_ovr_addr : cur_d;
    mem_req.data_raddr = cur_d;
  end

  // output register
  always_comb begin
    oval_d   = oval_q;
    ost_d    = ost_q;
    oelem_d  = oelem_q;
    ocount_d = ocount_q;
    olast_d  = olast_q;
    if (push) begin
      oval_d   = 1'b1;
      ost_d    = push_st;
      oelem_d  = push_elem;
      ocount_d = cnt_x[COUNT_W-1:0];
      olast_d  = push_last;
    end else if (out_o.ready) begin
      oval_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      free_head_q <= idx_t'(1);
      list_head_q <= HEAD_FREE;
      count_q     <= '0;
      init_idx_q  <= idx_t'(1);
      op_q        <= '0;
      oval_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      list_head_q <= list_head_d;
      count_q     <= count_d;
      init_idx_q  <= init_idx_d;
      op_q        <= op_d;
      oval_q      <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    steps_q      <= steps_d;
    j_q          <= j_d;
    val_q        <= val_d;
    rsp_status_q <= rsp_status_d;
    ost_q        <= ost_d;
    oelem_q      <= oelem_d;
    ocount_q     <= ocount_d;
    olast_q      <= olast_d;
  end

  assign out_o.valid   = oval_q;
  assign out_o.status  = ost_q;
  assign out_o.element = $signed(oelem_q);
  assign out_o.count   = ocount_q;
  assign out_o.last    = olast_q;

endmodule

FILE: rtl/cll_chk.sv
// ----------------------------------------------------------------------------
// cll_chk
// port level checks of the linked list engine, bound to the top level
// ----------------------------------------------------------------------------
`include "cursor_linked_list_engine_core_macros.svh"

module cll_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [cll_pkg::ST_W-1:0]   out_status_i,
  input logic [cll_pkg::ELEM_W-1:0] out_element_i,
  input logic [cll_pkg::COUNT_W-1:0] out_count_i,
  input logic                       out_last_i
);
  import cll_pkg::*;

  // stalled result stays put
  `CLL_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
    out_valid_i && $stable(out_status_i) && $stable(out_element_i) && $stable(out_count_i) && $stable(out_last_i))

  // a status other than ok closes the request and carries no element
  `CLL_ASSERT_IMP(a_err_single, clk_i, rst_ni, out_valid_i && (out_status_i != ST_OK),
    out_last_i && (out_element_i == '0))

  // an empty readout reports an empty list
  `CLL_ASSERT_IMP(a_empty_count, clk_i, rst_ni, out_valid_i && (out_status_i == ST_EMPTY),
    out_count_i == '0)

  // an ok result that is not the last one never reports an empty list
  `CLL_ASSERT_IMP(a_ok_nonempty, clk_i, rst_ni,
    out_valid_i && (out_status_i == ST_OK) && !out_last_i, out_count_i != '0)

endmodule

bind cursor_linked_list_engine_core cll_chk u_cll_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_status_i  (out_o.status),
  .out_element_i (out_o.element),
  .out_count_i   (out_o.count),
  .out_last_i    (out_o.last)
);
